// ----- src/bdpc_pkg.sv -----
// Package for the button debounce and press classifier.
// Holds the field widths, configuration codes and reset values, and the payload structs.
// Depends on nothing.
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int HELD_W     = 31;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_W-1:0]  DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0]  LONG_PRESS_RST = 16'd1000;
  localparam logic [HELD_W-1:0] HELD_MAX       = {HELD_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1
  } cfg_addr_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic              press_event;
    logic              release_event;
    logic              short_press_event;
    logic              long_press_event;
    logic              is_held;
    logic              long_has_fired;
    logic [HELD_W-1:0] held_time;
  } result_t;

endpackage

// ----- src/bdpc_if.sv -----
// Channel interfaces for the button debounce and press classifier.
// Sample, result and configuration channels with valid/ready handshakes.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

interface bdpc_sample_if;
  import bdpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              raw_level;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, raw_level, now_ms, input ready);
  modport sink   (input valid, raw_level, now_ms, output ready);
endinterface

interface bdpc_result_if;
  import bdpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              press_event;
  logic              release_event;
  logic              short_press_event;
  logic              long_press_event;
  logic              is_held;
  logic              long_has_fired;
  logic [HELD_W-1:0] held_time;
  modport source (output valid, press_event, release_event, short_press_event,
                  long_press_event, is_held, long_has_fired, held_time, input ready);
  modport sink   (input valid, press_event, release_event, short_press_event,
                  long_press_event, is_held, long_has_fired, held_time, output ready);
endinterface

interface bdpc_cfg_if;
  import bdpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_W-1:0]      data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/bdpc_cfg_regs.sv -----
// Configuration register file: debounce time and long press time.
// Depends on bdpc_pkg and bdpc_cfg_if.
`timescale 1ns / 1ps

module bdpc_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  bdpc_cfg_if.sink        cfg,
  output bdpc_pkg::cfg_t  cfg_q
);
  import bdpc_pkg::*;

  // Writes must come only while the block is idle; the block leaves this unenforced. The port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.debounce_time   <= DEBOUNCE_RST;
      cfg_q.long_press_time <= LONG_PRESS_RST;
    end else if (cfg.valid) begin
      case (cfg_addr_t'(cfg.addr))
        CFG_DEBOUNCE: begin
          cfg_q.debounce_time <= cfg.data;
        end
        CFG_LONG_PRESS: begin
          cfg_q.long_press_time <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/bdpc_core.sv -----
// Debounce and press classification logic with its state registers.
// One sample is evaluated per step; the state advances on the same edge.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bdpc_pkg::sample_t smp,
  input  bdpc_pkg::cfg_t    cfg_q,
  output bdpc_pkg::result_t res
);
  import bdpc_pkg::*;

  logic              last_raw,     last_raw_next;
  logic [TIME_W-1:0] change_time,  change_time_next;
  logic              stable_level, stable_level_next;
  logic              held_flag,    held_flag_next;
  logic [TIME_W-1:0] press_time,   press_time_next;
  logic              long_done,    long_done_next;

  logic              changed;
  logic              settled;
  logic [TIME_W-1:0] d_change;
  logic [TIME_W-1:0] d_press;
  logic [TIME_W-1:0] d_hold;

  always_comb begin
    changed  = smp.raw_level != last_raw;
    d_change = smp.now_ms - change_time;
    d_press  = smp.now_ms - press_time;
    // A fresh raw change gives a zero settle time, so only a zero debounce passes.
    settled  = changed ? (cfg_q.debounce_time == '0)
                       : (d_change >= {{(TIME_W-CFG_W){1'b0}}, cfg_q.debounce_time});

    last_raw_next     = smp.raw_level;
    change_time_next  = changed ? smp.now_ms : change_time;
    stable_level_next = stable_level;
    held_flag_next    = held_flag;
    press_time_next   = press_time;
    long_done_next    = long_done;

    res.press_event       = 1'b0;
    res.release_event     = 1'b0;
    res.short_press_event = 1'b0;
    res.long_press_event  = 1'b0;

    if (settled) begin
      stable_level_next = smp.raw_level;
      if (stable_level && !smp.raw_level) begin
        held_flag_next  = 1'b1;
        press_time_next = smp.now_ms;
        long_done_next  = 1'b0;
        res.press_event = 1'b1;
      end
      if (!stable_level && smp.raw_level) begin
        res.release_event     = 1'b1;
        res.short_press_event = held_flag && !long_done;
        held_flag_next        = 1'b0;
      end
    end

    // Hold time measured against the press time in force after this sample.
    d_hold = res.press_event ? '0 : d_press;

    if (settled && held_flag_next && !long_done_next &&
        d_hold >= {{(TIME_W-CFG_W){1'b0}}, cfg_q.long_press_time}) begin
      long_done_next       = 1'b1;
      res.long_press_event = 1'b1;
    end

    res.is_held        = held_flag_next;
    res.long_has_fired = long_done_next;
    if (!held_flag_next) begin
      res.held_time = '0;
    end else if (d_hold[TIME_W-1]) begin
      res.held_time = HELD_MAX;
    end else begin
      res.held_time = d_hold[HELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b1;
      change_time  <= '0;
      stable_level <= 1'b1;
      held_flag    <= 1'b0;
      press_time   <= '0;
      long_done    <= 1'b0;
    end else if (step) begin
      last_raw     <= last_raw_next;
      change_time  <= change_time_next;
      stable_level <= stable_level_next;
      held_flag    <= held_flag_next;
      press_time   <= press_time_next;
      long_done    <= long_done_next;
    end
  end

  a_press_xor_release: assert property (@(posedge clk) disable iff (rst)
    step |-> !(res.press_event && res.release_event))
    else $error("press and release reported on the same sample");

  a_short_needs_release: assert property (@(posedge clk) disable iff (rst)
    step && res.short_press_event |-> res.release_event && !res.is_held)
    else $error("short press without a release");

  a_long_state: assert property (@(posedge clk) disable iff (rst)
    step && res.long_press_event |=> held_flag && long_done)
    else $error("long press fired but hold state not recorded");

  a_held_matches_level: assert property (@(posedge clk) disable iff (rst)
    held_flag |-> !stable_level)
    else $error("held flag set while debounced level is released");

endmodule

// ----- src/button_debounce_press_classifier_unit.sv -----
// Top level of the button debounce and press classifier.
// Input register, classification core, result register and configuration registers.
// Depends on bdpc_pkg, bdpc_if, bdpc_cfg_regs and bdpc_core.
//
//   Channel  Dir   Payload                                        Transaction
//   sample   in    raw_level, now_ms                              one poll
//   result   out   press/release/short/long events, is_held,      one result per poll
//                  long_has_fired, held_time
//   cfg      in    addr (0 debounce, 1 long press), data          one register write
//
// Throughput is one poll per clock while the sink keeps taking results. A poll accepted into
// the input register passes through the core into the result register, where the sink takes it.
// The input register and the result register decouple the two sides, so a new poll is
// accepted into an empty input register while a finished result waits for the sink.
// The loop that bounds the rate is the core's press state update, one sample per cycle when stepped.
// Reset is synchronous and restores the register defaults and the released button state.
`timescale 1ns / 1ps

module button_debounce_press_classifier_unit (
  input  logic          clk,
  input  logic          rst,
  bdpc_cfg_if.sink      cfg,
  bdpc_sample_if.sink   sample,
  bdpc_result_if.source result
);
  import bdpc_pkg::*;

  cfg_t    cfg_q;
  logic    s1_valid;
  sample_t s1_smp;
  logic    out_valid;
  result_t res;
  result_t res_q;
  logic    advance;

  bdpc_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  assign advance      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || advance;

  bdpc_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .smp   (s1_smp),
    .cfg_q (cfg_q),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sample.ready) begin
        s1_valid <= sample.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_smp.raw_level <= sample.raw_level;
      s1_smp.now_ms    <= sample.now_ms;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.press_event       = res_q.press_event;
  assign result.release_event     = res_q.release_event;
  assign result.short_press_event = res_q.short_press_event;
  assign result.long_press_event  = res_q.long_press_event;
  assign result.is_held           = res_q.is_held;
  assign result.long_has_fired    = res_q.long_has_fired;
  assign result.held_time         = res_q.held_time;

endmodule

// ----- verif/bdpc_press_checker.sv -----
// Scoreboard for the button debounce and press classifier.
// Watches the cfg, sample and result channels, predicts each result and compares it.
// Depends on bdpc_pkg and bdpc_if.
`timescale 1ns / 1ps

module bdpc_press_checker
  import bdpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  bdpc_cfg_if    cfg,
  bdpc_sample_if sample,
  bdpc_result_if result,
  output int     mismatch_count,
  output int     reports_due
);

  // Shadow copy of the configuration registers.
  logic [CFG_W-1:0]  settle_ms;
  logic [CFG_W-1:0]  hold_ms;

  // Shadow copy of the button state.
  logic              last_raw;
  logic [TIME_W-1:0] change_ms;
  logic              stable_lvl;
  logic              held;
  logic [TIME_W-1:0] press_ms;
  logic              long_done;

  result_t press_reports_q[$];

  task automatic clear_button_state();
    settle_ms   = DEBOUNCE_RST;
    hold_ms     = LONG_PRESS_RST;
    last_raw    = 1'b1;
    change_ms   = '0;
    stable_lvl  = 1'b1;
    held        = 1'b0;
    press_ms    = '0;
    long_done   = 1'b0;
  endtask

  task automatic classify_poll(input logic raw, input logic [TIME_W-1:0] t, output result_t r);
    logic              prev;
    logic [TIME_W-1:0] since;
    r = '0;
    if (raw != last_raw) begin
      change_ms = t;
      last_raw  = raw;
    end
    since = t - change_ms;
    if (since >= settle_ms) begin
      prev       = stable_lvl;
      stable_lvl = raw;
      if (prev && !raw) begin
        held          = 1'b1;
        press_ms      = t;
        long_done     = 1'b0;
        r.press_event = 1'b1;
      end
      if (!prev && raw) begin
        r.release_event     = 1'b1;
        r.short_press_event = held && !long_done;
        held                = 1'b0;
      end
      since = t - press_ms;
      if (held && !long_done && since >= hold_ms) begin
        long_done          = 1'b1;
        r.long_press_event = 1'b1;
      end
    end
    r.is_held        = held;
    r.long_has_fired = long_done;
    if (held) begin
      since       = t - press_ms;
      // Anything at or beyond 2^31 ms clamps to the largest held time.
      r.held_time = since[TIME_W-1] ? HELD_MAX : since[HELD_W-1:0];
    end
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    reports_due    = 0;
    clear_button_state();
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      clear_button_state();
      press_reports_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          CFG_DEBOUNCE:   settle_ms = cfg.data;
          CFG_LONG_PRESS: hold_ms   = cfg.data;
          default: ;
        endcase
      end
      // A result accepted on this edge can never belong to a poll accepted on the same edge.
      if (result.valid && result.ready) begin
        if (press_reports_q.size() == 0) begin
          $error("result transaction with no poll outstanding");
          mismatch_count++;
        end else begin
          want = press_reports_q.pop_front();
          check_field("press_event",       want.press_event,       result.press_event);
          check_field("release_event",     want.release_event,     result.release_event);
          check_field("short_press_event", want.short_press_event, result.short_press_event);
          check_field("long_press_event",  want.long_press_event,  result.long_press_event);
          check_field("is_held",           want.is_held,           result.is_held);
          check_field("long_has_fired",    want.long_has_fired,    result.long_has_fired);
          check_field("held_time",         want.held_time,         result.held_time);
        end
      end
      if (sample.valid && sample.ready) begin
        classify_poll(sample.raw_level, sample.now_ms, got);
        press_reports_q.push_back(got);
      end
    end
    reports_due <= press_reports_q.size();
  end

endmodule

// ----- verif/button_debounce_press_classifier_unit_tb.sv -----
// Top of the testbench for the button debounce and press classifier.
// Drives directed and randomized button polls and register writes; depends on bdpc_pkg,
// bdpc_if, bdpc_press_checker and the block itself.
`timescale 1ns / 1ps

module button_debounce_press_classifier_unit_tb;
  import bdpc_pkg::*;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_ADDR = 2'd3;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   reports_due;

  int                polls_sent;
  int                burst_left;
  int                debounce_cur;
  int                long_cur;
  logic              level_cur;
  logic [TIME_W-1:0] now_cur;

  bdpc_cfg_if    cfg_ch();
  bdpc_sample_if sample_ch();
  bdpc_result_if result_ch();

  button_debounce_press_classifier_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  bdpc_press_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_ch),
    .sample         (sample_ch),
    .result         (result_ch),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: the stall mode is redrawn at random intervals, including free-flowing stretches.
  initial begin
    int mode;
    int mode_left;
    int cyc;
    mode_left       = 0;
    cyc             = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      cyc++;
      case (mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= 1'($urandom_range(0, 1));
        2:       result_ch.ready <= ($urandom_range(0, 7) == 0);
        default: result_ch.ready <= cyc[2];
      endcase
    end
  end

  task automatic post_poll(input logic raw, input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.raw_level <= raw;
    sample_ch.now_ms    <= t;
    do @(posedge clk); while (!sample_ch.ready);
    polls_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (addr == CFG_DEBOUNCE) debounce_cur = data;
    if (addr == CFG_LONG_PRESS) long_cur = data;
  endtask

  // Mostly complete presses and releases with contact bounce, some glitches and some noise.
  task automatic run_presses(input int n_polls);
    int   stop_at;
    int   kind;
    int   step;
    logic target;
    stop_at = polls_sent + n_polls;
    while (polls_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      step = (debounce_cur + long_cur) / 6 + 1;
      if (kind == 0) begin
        // Arbitrary time jumps reach saturation and backward timestamps.
        now_cur = $urandom_range(0, 1) ? $urandom : now_cur + $urandom_range(0, step);
        post_poll(1'($urandom_range(0, 1)), now_cur);
      end else if (kind == 1) begin
        now_cur += $urandom_range(0, debounce_cur);
        post_poll(~level_cur, now_cur);
        now_cur += $urandom_range(0, debounce_cur / 2);
        post_poll(level_cur, now_cur);
      end else begin
        target = ~level_cur;
        repeat ($urandom_range(0, 4)) begin
          now_cur += $urandom_range(0, debounce_cur / 2);
          post_poll(1'($urandom_range(0, 1)), now_cur);
        end
        repeat ($urandom_range(1, 20)) begin
          now_cur += $urandom_range(0, step);
          post_poll(target, now_cur);
        end
        level_cur = target;
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.raw_level = 1'b1;
    sample_ch.now_ms    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = CFG_DEBOUNCE;
    cfg_ch.data         = '0;
    polls_sent          = 0;
    burst_left          = 0;
    debounce_cur        = DEBOUNCE_RST;
    long_cur            = LONG_PRESS_RST;
    level_cur           = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: bounce, press, long press, release after long, short press.
    post_poll(1'b1, 32'd0);
    post_poll(1'b1, 32'd30);
    post_poll(1'b0, 32'd40);
    post_poll(1'b1, 32'd45);
    post_poll(1'b0, 32'd50);
    post_poll(1'b0, 32'd69);
    post_poll(1'b0, 32'd70);
    post_poll(1'b0, 32'd1069);
    post_poll(1'b0, 32'd1070);
    post_poll(1'b1, 32'd1510);
    post_poll(1'b1, 32'd1530);
    post_poll(1'b0, 32'd2000);
    post_poll(1'b0, 32'd2020);
    post_poll(1'b1, 32'd2100);
    post_poll(1'b1, 32'd2120);
    // Held time past 2^31 saturates, also across the timestamp wrap.
    post_poll(1'b0, 32'h1000_0000);
    post_poll(1'b0, 32'h1000_0014);
    post_poll(1'b0, 32'h9000_0014);
    post_poll(1'b0, 32'hFFFF_FFFF);
    post_poll(1'b0, 32'h0000_0005);
    // Timestamp going backwards still releases, since the difference wraps.
    post_poll(1'b1, 32'h0000_0000);
    post_poll(1'b1, 32'hFFFF_FFF0);
    wait_idle();

    // Zero debounce and zero hold time: press and long press on one poll.
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG_PRESS, 16'd0);
    post_poll(1'b0, 32'd100);
    post_poll(1'b0, 32'd100);
    post_poll(1'b1, 32'd101);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_DEBOUNCE, 16'hFFFF);
          write_reg(CFG_LONG_PRESS, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_DEBOUNCE, 16'd0);
          write_reg(CFG_LONG_PRESS, 16'd0);
        end
        2: begin
          write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 64)));
          write_reg(CFG_LONG_PRESS, CFG_W'($urandom_range(0, 400)));
        end
        3: begin
          write_reg(CFG_SPARE_ADDR, CFG_W'($urandom));
          write_reg(CFG_DEBOUNCE, DEBOUNCE_RST);
          write_reg(CFG_LONG_PRESS, LONG_PRESS_RST);
        end
        4: begin
          write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 65535)));
          write_reg(CFG_LONG_PRESS, CFG_W'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(1, 8)));
          write_reg(CFG_LONG_PRESS, CFG_W'($urandom_range(0, 40)));
        end
      endcase
      now_cur = $urandom;
      run_presses(225);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
